>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define E2Q_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("e2q: same-cycle check failed");

// Next-cycle implication, checked only outside reset.
`define E2Q_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("e2q: next-cycle check failed");

`endif

>>> rtl/e2q_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;

    localparam int ANGLE_W = 16;
    localparam int LIMIT_W = 14;
    localparam int QUAT_W  = 16;
    localparam logic [LIMIT_W-1:0] PITCH_LIMIT_RESET = 14'd12854;

    localparam int TRIG_ITERATIONS = 16;
    localparam int ATAN_ENTRIES    = 24;
    localparam int CORDIC_STAGES   = (TRIG_ITERATIONS < ATAN_ENTRIES) ?
                                     TRIG_ITERATIONS : ATAN_ENTRIES;

    // CORDIC datapath widths (Q.30 angles and vector components).
    localparam int ZW = 33;
    localparam int XW = 33;
    // Rounded cosine and sine, Q.20.
    localparam int TRIG_W = 22;

    // Pipeline register stages ahead of the output register:
    // two in angle preparation, the CORDIC steps plus its rounding stage,
    // and four in the product unit.
    localparam int PREP_STAGES = 2;
    localparam int MULT_STAGES = 4;
    localparam int NSTAGE = PREP_STAGES + CORDIC_STAGES + 1 + MULT_STAGES;

    localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
        32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
        32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128};

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 flip;
    } cordic_in_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } trig_t;

endpackage
`default_nettype wire

>>> rtl/e2q_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface e2q_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface
`default_nettype wire

>>> rtl/e2q_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface e2q_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               pitch_was_clipped;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, pitch_was_clipped,
                    input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, pitch_was_clipped,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/e2q_angle_prep.sv
`timescale 1ns / 1ps
`default_nettype none
module e2q_angle_prep (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [e2q_pkg::ANGLE_W-1:0] roll,
    input  wire logic signed [e2q_pkg::ANGLE_W-1:0] pitch,
    input  wire logic signed [e2q_pkg::ANGLE_W-1:0] yaw,
    input  wire logic        [e2q_pkg::LIMIT_W-1:0] limit,
    output e2q_pkg::cordic_in_t                     roll_start,
    output e2q_pkg::cordic_in_t                     pitch_start,
    output e2q_pkg::cordic_in_t                     yaw_start,
    output logic                                    clipped
);
    import e2q_pkg::*;

    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;

    // Half angle in Q.30 folded into [-pi/2, pi/2]; folding negates the result.
    function automatic cordic_in_t reduce(input logic signed [ANGLE_W-1:0] code);
        logic signed [33:0] z;
        cordic_in_t         r;
        z = signed'({{2{code[ANGLE_W-1]}}, code, 16'h0000});
        r.flip = 1'b1;
        if (z > HALF_PI_Q30) begin
            z = z - PI_Q30;
        end else if (z < -HALF_PI_Q30) begin
            z = z + PI_Q30;
        end else begin
            r.flip = 1'b0;
        end
        r.z = z[ZW-1:0];
        return r;
    endfunction

    logic signed [ANGLE_W:0]   pitch_ext;
    logic signed [ANGLE_W:0]   limit_ext;
    logic signed [ANGLE_W-1:0] pitch_next;
    logic                      clip_next;

    logic signed [ANGLE_W-1:0] roll_reg;
    logic signed [ANGLE_W-1:0] pitch_reg;
    logic signed [ANGLE_W-1:0] yaw_reg;
    logic                      clip_reg;
    cordic_in_t                roll_start_reg;
    cordic_in_t                pitch_start_reg;
    cordic_in_t                yaw_start_reg;

    always_comb
    begin
        pitch_ext  = signed'({pitch[ANGLE_W-1], pitch});
        limit_ext  = signed'({3'b000, limit});
        pitch_next = pitch;
        clip_next  = 1'b0;
        if (pitch_ext > limit_ext) begin
            pitch_next = limit_ext[ANGLE_W-1:0];
            clip_next  = 1'b1;
        end else if (pitch_ext < -limit_ext) begin
            pitch_next = ANGLE_W'(-limit_ext);
            clip_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            roll_reg        <= roll;
            pitch_reg       <= pitch_next;
            yaw_reg         <= yaw;
            clip_reg        <= clip_next;
            roll_start_reg  <= reduce(roll_reg);
            pitch_start_reg <= reduce(pitch_reg);
            yaw_start_reg   <= reduce(yaw_reg);
        end
    end

    assign roll_start  = roll_start_reg;
    assign pitch_start = pitch_start_reg;
    assign yaw_start   = yaw_start_reg;
    assign clipped     = clip_reg;
endmodule
`default_nettype wire

>>> rtl/e2q_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module e2q_cordic (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire e2q_pkg::cordic_in_t start,
    output e2q_pkg::trig_t           trig
);
    import e2q_pkg::*;

    logic signed [XW-1:0] x_reg    [CORDIC_STAGES];
    logic signed [XW-1:0] y_reg    [CORDIC_STAGES];
    logic signed [ZW-1:0] z_reg    [CORDIC_STAGES];
    logic                 flip_reg [CORDIC_STAGES];
    trig_t                trig_reg;

    // One rotation step per register stage.
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_step
        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic                 flip_in;
        logic signed [ZW-1:0] atan_val;

        if (i == 0) begin : g_first
            assign x_in    = CORDIC_GAIN_Q30;
            assign y_in    = '0;
            assign z_in    = start.z;
            assign flip_in = start.flip;
        end else begin : g_rest
            assign x_in    = x_reg[i-1];
            assign y_in    = y_reg[i-1];
            assign z_in    = z_reg[i-1];
            assign flip_in = flip_reg[i-1];
        end

        assign atan_val = signed'({1'b0, ATAN_Q30[i]});

        always_ff @(posedge clk)
        begin
            if (en) begin
                flip_reg[i] <= flip_in;
                if (!z_in[ZW-1]) begin
                    x_reg[i] <= x_in - (y_in >>> i);
                    y_reg[i] <= y_in + (x_in >>> i);
                    z_reg[i] <= z_in - atan_val;
                end else begin
                    x_reg[i] <= x_in + (y_in >>> i);
                    y_reg[i] <= y_in - (x_in >>> i);
                    z_reg[i] <= z_in + atan_val;
                end
            end
        end
    end

    logic signed [XW-1:0] x_fin;
    logic signed [XW-1:0] y_fin;
    logic signed [XW-1:0] c_round;
    logic signed [XW-1:0] s_round;

    // Undo the half-turn fold, then round Q.30 to Q.20.
    always_comb
    begin
        x_fin   = flip_reg[CORDIC_STAGES-1] ? -x_reg[CORDIC_STAGES-1] : x_reg[CORDIC_STAGES-1];
        y_fin   = flip_reg[CORDIC_STAGES-1] ? -y_reg[CORDIC_STAGES-1] : y_reg[CORDIC_STAGES-1];
        c_round = (x_fin + XW'(512)) >>> 10;
        s_round = (y_fin + XW'(512)) >>> 10;
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            trig_reg.c <= c_round[TRIG_W-1:0];
            trig_reg.s <= s_round[TRIG_W-1:0];
        end
    end

    assign trig = trig_reg;
endmodule
`default_nettype wire

>>> rtl/e2q_quat_mult.sv
`timescale 1ns / 1ps
`default_nettype none
module e2q_quat_mult (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire e2q_pkg::trig_t                    yaw,
    input  wire e2q_pkg::trig_t                    roll,
    input  wire e2q_pkg::trig_t                    pitch,
    output logic signed [e2q_pkg::QUAT_W-1:0]      quat_w,
    output logic signed [e2q_pkg::QUAT_W-1:0]      quat_x,
    output logic signed [e2q_pkg::QUAT_W-1:0]      quat_y,
    output logic signed [e2q_pkg::QUAT_W-1:0]      quat_z
);
    import e2q_pkg::*;

    localparam int PW  = 2 * TRIG_W;        // pair product
    localparam int HW  = 2 * TRIG_W;        // high partial
    localparam int LW  = 2 * TRIG_W + 1;    // low partial
    localparam int TW  = 3 * TRIG_W;        // triple product, Q.60
    localparam int SW  = TW + 1;            // sum of two triples
    localparam int RSH = 45;
    localparam logic signed [SW-1:0] ROUND_Q60 = SW'(1) <<< (RSH - 1);
    localparam logic signed [SW-RSH-1:0] Q15_MAX = (SW-RSH)'(32767);
    localparam logic signed [SW-RSH-1:0] Q15_MIN = -(SW-RSH)'(32768);

    function automatic logic signed [QUAT_W-1:0] sat_q15(input logic signed [SW-1:0] s);
        logic signed [SW-1:0]     sh;
        logic signed [SW-RSH-1:0] v;
        sh = s >>> RSH;
        v  = sh[SW-RSH-1:0];
        if (v > Q15_MAX) begin
            return 16'sh7fff;
        end else if (v < Q15_MIN) begin
            return 16'sh8000;
        end
        return v[QUAT_W-1:0];
    endfunction

    // Stage 1: yaw-roll pair products, pitch terms carried along.
    logic signed [PW-1:0]     p_reg [4];
    logic signed [TRIG_W-1:0] cp_reg;
    logic signed [TRIG_W-1:0] sp_reg;

    always_ff @(posedge clk)
    begin
        if (en) begin
            p_reg[0] <= yaw.c * roll.c;
            p_reg[1] <= yaw.s * roll.s;
            p_reg[2] <= yaw.c * roll.s;
            p_reg[3] <= yaw.s * roll.c;
            cp_reg   <= pitch.c;
            sp_reg   <= pitch.s;
        end
    end

    // Operand pairs for the eight triple products.
    logic signed [PW-1:0]     pa [8];
    logic signed [TRIG_W-1:0] pb [8];

    always_comb
    begin
        pa[0] = p_reg[0]; pb[0] = cp_reg;
        pa[1] = p_reg[1]; pb[1] = sp_reg;
        pa[2] = p_reg[2]; pb[2] = cp_reg;
        pa[3] = p_reg[3]; pb[3] = sp_reg;
        pa[4] = p_reg[0]; pb[4] = sp_reg;
        pa[5] = p_reg[1]; pb[5] = cp_reg;
        pa[6] = p_reg[3]; pb[6] = cp_reg;
        pa[7] = p_reg[2]; pb[7] = sp_reg;
    end

    // Stage 2: each pair product split in two halves so no multiplier exceeds 23 by 22.
    logic signed [HW-1:0] hi_reg [8];
    logic signed [LW-1:0] lo_reg [8];
    // Stage 3: triple products reassembled.
    logic signed [TW-1:0] t_reg  [8];

    for (genvar k = 0; k < 8; k++) begin : g_triple
        logic signed [TRIG_W-1:0] ph;
        logic signed [TRIG_W:0]   pl;

        assign ph = pa[k][PW-1:TRIG_W];
        assign pl = signed'({1'b0, pa[k][TRIG_W-1:0]});

        always_ff @(posedge clk)
        begin
            if (en) begin
                hi_reg[k] <= ph * pb[k];
                lo_reg[k] <= pl * pb[k];
                t_reg[k]  <= (TW'(hi_reg[k]) <<< TRIG_W) + TW'(lo_reg[k]);
            end
        end
    end

    // Stage 4: the four sums with the rounding offset.
    logic signed [SW-1:0] sum_reg [4];

    always_ff @(posedge clk)
    begin
        if (en) begin
            sum_reg[0] <= SW'(t_reg[0]) + SW'(t_reg[1]) + ROUND_Q60;
            sum_reg[1] <= SW'(t_reg[2]) - SW'(t_reg[3]) + ROUND_Q60;
            sum_reg[2] <= SW'(t_reg[4]) + SW'(t_reg[5]) + ROUND_Q60;
            sum_reg[3] <= SW'(t_reg[6]) - SW'(t_reg[7]) + ROUND_Q60;
        end
    end

    assign quat_w = sat_q15(sum_reg[0]);
    assign quat_x = sat_q15(sum_reg[1]);
    assign quat_y = sat_q15(sum_reg[2]);
    assign quat_z = sat_q15(sum_reg[3]);
endmodule
`default_nettype wire

>>> rtl/euler_rpy_to_quaternion.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Converts roll, pitch and yaw (signed Q3.13 radians) to the ZYX unit quaternion (Q1.15).
// Channel angles: one transaction carries the three angles; quat: one transaction carries
// w, x, y, z and a flag that reports when pitch was clipped to the configured limit.
// cfg_wr_en with cfg_wr_data sets the pitch limit; write it only while the block is idle.
// The datapath is a single pipeline: two angle preparation stages, one CORDIC stage per
// rotation step (sixteen) with three CORDICs side by side, one rounding stage, four
// product stages, then the output register.
// The edge that accepts an input transaction loads the first of 24 register stages, and the
// result passes through them in order to the output register. Throughput is one
// transaction per cycle as long as the pipeline is not held by a stalled receiver.
// When the receiver stalls, the result waits in the output register and the pipeline keeps
// moving as long as its last stage is empty; once that stage holds an item too, the whole
// pipeline holds and angles.ready falls, so nothing is dropped or repeated.
// Reset clears all valid bits and the output valid, and restores the pitch limit of
// 89.9 degrees; payload registers are left as they are.
module euler_rpy_to_quaternion (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    e2q_in_if.sink                             angles,
    e2q_out_if.source                          quat,
    input  wire logic                          cfg_wr_en,
    input  wire logic [e2q_pkg::LIMIT_W-1:0]   cfg_wr_data
);
    import e2q_pkg::*;

    localparam int LAST = NSTAGE - 1;

    logic [LIMIT_W-1:0] pitch_limit_reg;
    logic [NSTAGE-1:0]  vld_reg;
    logic [NSTAGE-1:0]  vld_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               en;

    // The pipeline advances unless its last stage holds a result that cannot leave.
    assign en           = !vld_reg[LAST] || !out_valid_reg || quat.ready;
    assign angles.ready = en;

    cordic_in_t roll_start;
    cordic_in_t pitch_start;
    cordic_in_t yaw_start;
    logic       clipped;
    trig_t      roll_trig;
    trig_t      pitch_trig;
    trig_t      yaw_trig;

    logic signed [QUAT_W-1:0] mult_w;
    logic signed [QUAT_W-1:0] mult_x;
    logic signed [QUAT_W-1:0] mult_y;
    logic signed [QUAT_W-1:0] mult_z;

    e2q_angle_prep u_prep (
        .clk         (clk),
        .en          (en),
        .roll        (angles.roll_angle),
        .pitch       (angles.pitch_angle),
        .yaw         (angles.yaw_angle),
        .limit       (pitch_limit_reg),
        .roll_start  (roll_start),
        .pitch_start (pitch_start),
        .yaw_start   (yaw_start),
        .clipped     (clipped)
    );

    e2q_cordic u_cordic_roll  (.clk(clk), .en(en), .start(roll_start),  .trig(roll_trig));
    e2q_cordic u_cordic_pitch (.clk(clk), .en(en), .start(pitch_start), .trig(pitch_trig));
    e2q_cordic u_cordic_yaw   (.clk(clk), .en(en), .start(yaw_start),   .trig(yaw_trig));

    e2q_quat_mult u_mult (
        .clk    (clk),
        .en     (en),
        .yaw    (yaw_trig),
        .roll   (roll_trig),
        .pitch  (pitch_trig),
        .quat_w (mult_w),
        .quat_x (mult_x),
        .quat_y (mult_y),
        .quat_z (mult_z)
    );

    // The clip flag is known after the first stage and travels beside the datapath.
    logic flag_reg [NSTAGE-1];

    always_ff @(posedge clk)
    begin
        if (en) begin
            flag_reg[0] <= clipped;
            for (int i = 1; i < NSTAGE - 1; i++) begin
                flag_reg[i] <= flag_reg[i-1];
            end
        end
    end

    always_comb
    begin
        vld_next       = vld_reg;
        out_valid_next = out_valid_reg;
        if (en) begin
            vld_next = {vld_reg[NSTAGE-2:0], angles.valid};
            if (vld_reg[LAST]) begin
                out_valid_next = 1'b1;
            end else if (quat.ready) begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pitch_limit_reg <= PITCH_LIMIT_RESET;
            vld_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                pitch_limit_reg <= cfg_wr_data;
            end
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    logic signed [QUAT_W-1:0] out_w_reg;
    logic signed [QUAT_W-1:0] out_x_reg;
    logic signed [QUAT_W-1:0] out_y_reg;
    logic signed [QUAT_W-1:0] out_z_reg;
    logic                     out_clip_reg;

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[LAST]) begin
            out_w_reg    <= mult_w;
            out_x_reg    <= mult_x;
            out_y_reg    <= mult_y;
            out_z_reg    <= mult_z;
            out_clip_reg <= flag_reg[NSTAGE-2];
        end
    end

    assign quat.valid             = out_valid_reg;
    assign quat.quat_w            = out_w_reg;
    assign quat.quat_x            = out_x_reg;
    assign quat.quat_y            = out_y_reg;
    assign quat.quat_z            = out_z_reg;
    assign quat.pitch_was_clipped = out_clip_reg;

    // An accepted transaction always occupies the first stage.
    `E2Q_ASSERT_NEXT(a_accept_enters, angles.valid && angles.ready, vld_reg[0])
    // A waiting result with a full last stage must hold off the input.
    `E2Q_ASSERT_IMPLIES(a_stall_blocks, out_valid_reg && !quat.ready && vld_reg[LAST], !en)
    // While held, no valid bit moves.
    `E2Q_ASSERT_NEXT(a_hold_stable, !en, $stable(vld_reg) && out_valid_reg)
endmodule
`default_nettype wire

>>> sim/tb_channels.sv
`timescale 1ns / 1ps
// The block's own interfaces (e2q_in_if, e2q_out_if) carry both channels; this file
// holds the result record type that the testbench shares between its processes.
package tb_e2q_pkg;
    import e2q_pkg::*;

    typedef struct {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
        logic                     clipped;
    } quat_result_t;
endpackage

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the Euler angle to quaternion converter.
// Each angle transaction that the block accepts is run through a local model of the
// CORDIC half-angle trigonometry and the ZYX product formulas. The predicted quaternion
// is queued, and every result transaction is compared with the oldest prediction.
module tb_top;
    import e2q_pkg::*;
    import tb_e2q_pkg::*;

    localparam int LATENCY     = 24;
    localparam int WATCHDOG    = 5000;
    localparam int LIMIT_MAX   = 12868;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data = '0;

    e2q_in_if  angles();
    e2q_out_if quat();

    euler_rpy_to_quaternion u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .angles     (angles),
        .quat       (quat),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #5 clk = ~clk;

    // Predictor state: the pitch limit as the block should hold it.
    logic [LIMIT_W-1:0] model_limit;
    quat_result_t       pending_quats[$];
    int                 mismatches = 0;
    int                 idle_cycles = 0;
    bit                 sender_idles = 1'b1;
    bit                 receiver_idles = 1'b1;
    int                 hold_off = 0;
    int                 idle_left = 0;
    int                 hold_requests = 0;
    int                 holds_started = 0;

    localparam longint ATAN_TAB [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516,  16775851,  8388437,   4194283,   2097149,
        1048576,   524288,    262144,    131072,    65536,
        32768,     16384,     8192,      4096,      2048,
        1024,      512,       256,       128};

    // Cosine and sine of half the angle, Q.20, by the same CORDIC recipe as the block.
    task automatic half_angle_trig(input longint code, output longint c, output longint s);
        longint z, x, y, xs, ys;
        bit flip;
        z = code * 65536;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1686629713)
        begin
            z -= 64'sd3373259426;
            flip = 1'b1;
        end
        else if (z < -64'sd1686629713)
        begin
            z += 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < TRIG_ITERATIONS && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z -= ATAN_TAB[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z += ATAN_TAB[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = (x + 512) >>> 10;
        s = (y + 512) >>> 10;
    endtask

    // Rounds a Q.60 sum of two triple products to Q1.15 with saturation.
    function automatic logic signed [15:0] round_q15(input longint q60);
        longint v;
        v = (q60 + (64'sd1 <<< 44)) >>> 45;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    task automatic predict_quaternion(input logic signed [15:0] roll,
                                      input logic signed [15:0] pitch,
                                      input logic signed [15:0] yaw);
        longint p, lim, cy, sy, cr, sr, cp, sp;
        quat_result_t q;
        p = pitch;
        lim = model_limit;
        q.clipped = 1'b0;
        if (p > lim)
        begin
            p = lim;
            q.clipped = 1'b1;
        end
        else if (p < -lim)
        begin
            p = -lim;
            q.clipped = 1'b1;
        end
        half_angle_trig(yaw, cy, sy);
        half_angle_trig(roll, cr, sr);
        half_angle_trig(p, cp, sp);
        q.w = round_q15(cy * cr * cp + sy * sr * sp);
        q.x = round_q15(cy * sr * cp - sy * cr * sp);
        q.y = round_q15(cy * cr * sp + sy * sr * cp);
        q.z = round_q15(sy * cr * cp - cy * sr * sp);
        pending_quats.insert(pending_quats.size(), q);
    endtask

    // Offers one angle transaction, with an optional burst of idle cycles ahead of it.
    // The valid stays high from one transaction to the next when no idle falls between.
    task automatic send_angles(input logic signed [15:0] roll,
                               input logic signed [15:0] pitch,
                               input logic signed [15:0] yaw);
        int gap;
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            angles.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        angles.valid       <= 1'b1;
        angles.roll_angle  <= roll;
        angles.pitch_angle <= pitch;
        angles.yaw_angle   <= yaw;
        do
            @(posedge clk);
        while (!angles.ready);
        predict_quaternion(roll, pitch, yaw);
    endtask

    task automatic drain_pipeline();
        angles.valid <= 1'b0;
        while (pending_quats.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_pitch_limit(input logic [LIMIT_W-1:0] value);
        drain_pipeline();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model_limit = value;
    endtask

    function automatic logic signed [15:0] random_angle();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 65535) & 16'h3FFF);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Pitch near the limit is where clipping decides the result.
    function automatic logic signed [15:0] random_pitch();
        int off;
        off = $urandom_range(0, 40) - 20;
        case ($urandom_range(0, 3))
            0: return 16'(int'(model_limit) + off);
            1: return 16'(-(int'(model_limit) + off));
            default: return random_angle();
        endcase
    endfunction

    task automatic test_directed_extremes();
        logic signed [15:0] corners[6] = '{16'sh0000, 16'sh7FFF, 16'sh8000,
                                           16'sh3244, 16'shCDBC, 16'sh6488};
        foreach (corners[i])
            send_angles(corners[i], corners[(i + 1) % 6], corners[(i + 2) % 6]);
        send_angles(16'sh0000, 16'sh0000, 16'sh0000);
        // Pitch exactly on and just over the limit, both signs.
        send_angles(16'sh1000, 16'(int'(model_limit)), 16'sh0800);
        send_angles(16'sh1000, 16'(int'(model_limit) + 1), 16'sh0800);
        send_angles(16'sh1000, 16'(-int'(model_limit)), 16'sh0800);
        send_angles(16'sh1000, 16'(-int'(model_limit) - 1), 16'sh0800);
        send_angles(16'sh5555, 16'shAAAA, 16'sh5555);
        send_angles(16'shAAAA, 16'sh5555, 16'shAAAA);
    endtask

    task automatic test_limit_settings();
        logic [LIMIT_W-1:0] limits[5] = '{14'd0, 14'(LIMIT_MAX), 14'h3FFF, 14'd6000, 14'd1};
        foreach (limits[i])
        begin
            write_pitch_limit(limits[i]);
            repeat (40)
                send_angles(random_angle(), random_pitch(), random_angle());
        end
        write_pitch_limit(PITCH_LIMIT_RESET);
    endtask

    task automatic test_random_angles(input int count);
        repeat (count)
            send_angles(random_angle(), random_pitch(), random_angle());
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall its input.
    task automatic test_backpressure();
        drain_pipeline();
        hold_requests++;
        repeat (80)
            send_angles(random_angle(), random_pitch(), random_angle());
    endtask

    initial
    begin
        angles.valid       <= 1'b0;
        angles.roll_angle  <= '0;
        angles.pitch_angle <= '0;
        angles.yaw_angle   <= '0;
        model_limit = PITCH_LIMIT_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_limit_settings();
        test_backpressure();
        test_random_angles(1100);
        // Last part of the run: both sides at full rate.
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        test_random_angles(150);
        drain_pipeline();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stall bursts, plus the long hold-off when one is asked for.
    always @(posedge clk)
    begin
        if (!rst_n)
            quat.ready <= 1'b0;
        else if (holds_started != hold_requests)
        begin
            holds_started <= hold_requests;
            hold_off      <= 119;
            quat.ready    <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            quat.ready <= 1'b0;
        end
        else if (idle_left > 0)
        begin
            idle_left <= idle_left - 1;
            quat.ready <= 1'b0;
        end
        else if (receiver_idles && $urandom_range(0, 4) == 0)
        begin
            idle_left <= $urandom_range(0, 7);
            quat.ready <= 1'b0;
        end
        else
            quat.ready <= 1'b1;
    end

    // Result checker: every result transaction against the oldest prediction.
    always @(posedge clk)
    begin
        quat_result_t q;
        if (rst_n && quat.valid && quat.ready)
        begin
            if (pending_quats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result w=%0d x=%0d y=%0d z=%0d",
                             quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
            end
            else
            begin
                q = pending_quats.pop_front();
                if (q.w !== quat.quat_w || q.x !== quat.quat_x || q.y !== quat.quat_y ||
                    q.z !== quat.quat_z || q.clipped !== quat.pitch_was_clipped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0d %0d c%0b, got %0d %0d %0d %0d c%0b",
                                 q.w, q.x, q.y, q.z, q.clipped, quat.quat_w, quat.quat_x,
                                 quat.quat_y, quat.quat_z, quat.pitch_was_clipped);
                end
            end
        end
    end

    // Watchdog: cycles in which no transaction moves on either channel.
    always @(posedge clk)
    begin
        if ((angles.valid && angles.ready) || (quat.valid && quat.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end
endmodule

>>> euler_rpy_to_quaternion.f
+incdir+rtl
rtl/e2q_pkg.sv
rtl/e2q_in_if.sv
rtl/e2q_out_if.sv
rtl/e2q_angle_prep.sv
rtl/e2q_cordic.sv
rtl/e2q_quat_mult.sv
rtl/euler_rpy_to_quaternion.sv
sim/tb_channels.sv
sim/tb_top.sv
